[rtl/mtsd_pkg.sv]
package mtsd_pkg;

	localparam int RAW_W            = 16;
	localparam int LONG_W           = 32;
	localparam int SECTOR_W         = 8;
	localparam int LONG_INDEX_W     = 7;
	localparam int CFG_INDEX_W      = 1;
	localparam int CFG_DATA_W       = 16;

	localparam int LONGS_PER_SECTOR = 128;
	localparam int LABEL_WORDS      = 24;
	localparam int GAP_WORDS        = 4;
	localparam int QUEUE_DEPTH      = 2;

	localparam logic [LONG_W-1:0] MFM_MASK = 32'h5555_5555;

	localparam logic [RAW_W-1:0]    SYNC_WORD_RESET         = 16'h4489;
	localparam logic [SECTOR_W-1:0] SECTORS_PER_TRACK_RESET = 8'd11;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_SYNC_WORD         = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_SECTORS_PER_TRACK = 1'b1;

	typedef struct packed {
		logic [RAW_W-1:0]    sync_word;
		logic [SECTOR_W-1:0] sectors_per_track;
	} cfg_t;

	typedef struct packed {
		logic [SECTOR_W-1:0]     sector_number;
		logic [LONG_INDEX_W-1:0] long_index;
		logic [LONG_W-1:0]       odd_long;
		logic [LONG_W-1:0]       even_long;
		logic                    track_last;
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [LONG_W-1:0] mfm_join(input logic [LONG_W-1:0] odd,
		input logic [LONG_W-1:0] even);
		mfm_join = ((odd & MFM_MASK) << 1) | (even & MFM_MASK);
	endfunction

endpackage

[rtl/mtsd_if.sv]
interface mtsd_in_if import mtsd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] raw_word;
	logic             first_word;

	modport source(output valid, raw_word, first_word, input ready);
	modport sink(input valid, raw_word, first_word, output ready);
endinterface

interface mtsd_out_if import mtsd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [SECTOR_W-1:0]     sector_number;
	logic [LONG_INDEX_W-1:0] long_index;
	logic [LONG_W-1:0]       decoded_long;
	logic                    track_last;

	modport source(output valid, sector_number, long_index, decoded_long, track_last,
		input ready);
	modport sink(input valid, sector_number, long_index, decoded_long, track_last,
		output ready);
endinterface

[rtl/mtsd_ram.sv]
module mtsd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

[rtl/mtsd_front.sv]
module mtsd_front import mtsd_pkg::*; #(
	parameter int LONGS = LONGS_PER_SECTOR
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	mtsd_in_if.sink                  raw_in,
	input  q_stat_t                  q_stat,
	output q_push_t                  push,
	output logic                     ram_we,
	output logic [$clog2(LONGS)-1:0] ram_waddr,
	output logic [LONG_W-1:0]        ram_wdata,
	output logic                     ram_re,
	output logic [$clog2(LONGS)-1:0] ram_raddr,
	input  logic [LONG_W-1:0]        ram_rdata
);

	localparam int IW = $clog2(LONGS);
	localparam int CW = IW + 1;

	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_HEADER   = 3'd1;
	localparam logic [2:0] PH_LABELS   = 3'd2;
	localparam logic [2:0] PH_ODD      = 3'd3;
	localparam logic [2:0] PH_EVEN     = 3'd4;
	localparam logic [2:0] PH_GAP      = 3'd5;
	localparam logic [2:0] PH_HUNT     = 3'd6;
	localparam logic [2:0] PH_SKIPSYNC = 3'd7;

	logic [2:0]          phase_q;
	logic [CW-1:0]       wcnt_q;
	logic [RAW_W-1:0]    hold_q;
	logic [LONG_W-1:0]   hdr_odd_q;
	logic [SECTOR_W-1:0] sector_q;
	logic                gap_q;
	logic [SECTOR_W-1:0] left_q;

	logic                accept;
	logic                first;
	logic [RAW_W-1:0]    w;
	logic                lo_half;
	logic [IW-1:0]       idx;
	logic [CW:0]         wcnt_inc;
	logic [LONG_W-1:0]   cur_long;
	logic [LONG_W-1:0]   hdr_join;
	logic                last_long;
	logic                is_sync;

	assign raw_in.ready = !q_stat.full;

	assign accept    = raw_in.valid && raw_in.ready;
	assign first     = raw_in.first_word;
	assign w         = raw_in.raw_word;
	assign lo_half   = wcnt_q[0];
	assign idx       = wcnt_q[CW-1:1];
	assign wcnt_inc  = {1'b0, wcnt_q} + (CW+1)'(1);
	assign cur_long  = {hold_q, w};
	assign hdr_join  = mfm_join(hdr_odd_q, cur_long);
	assign last_long = idx == IW'(LONGS - 1);
	assign is_sync   = w == cfg.sync_word;

	// odd halves go to the store; the store is read on the high word of the
	// even half so its registered data is ready when the low word comes in
	always_comb begin
		ram_we    = accept && !first && phase_q == PH_ODD && lo_half;
		ram_waddr = idx;
		ram_wdata = cur_long;
		ram_re    = accept && !first && phase_q == PH_EVEN && !lo_half;
		ram_raddr = idx;

		push.valid                  = accept && !first && phase_q == PH_EVEN && lo_half;
		push.entry.sector_number    = sector_q;
		push.entry.long_index       = LONG_INDEX_W'(idx);
		push.entry.odd_long         = ram_rdata;
		push.entry.even_long        = cur_long;
		push.entry.track_last       = last_long && left_q == SECTOR_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			wcnt_q    <= '0;
			hold_q    <= '0;
			hdr_odd_q <= '0;
			sector_q  <= '0;
			gap_q     <= 1'b0;
			left_q    <= '0;
		end else if (accept) begin
			if (first) begin
				left_q  <= cfg.sectors_per_track;
				phase_q <= PH_HEADER;
				if (is_sync) begin
					wcnt_q <= '0;
				end else begin
					hold_q <= w;
					wcnt_q <= CW'(1);
				end
			end else begin
				case (phase_q)
					PH_HEADER: begin
						if (!lo_half) begin
							hold_q <= w;
							wcnt_q <= wcnt_inc[CW-1:0];
						end else if (wcnt_q == CW'(1)) begin
							hdr_odd_q <= cur_long;
							wcnt_q    <= wcnt_inc[CW-1:0];
						end else begin
							sector_q <= hdr_join[15:8];
							gap_q    <= hdr_join[7:0] == 8'd1;
							phase_q  <= PH_LABELS;
							wcnt_q   <= '0;
						end
					end
					PH_LABELS: begin
						if (wcnt_inc >= (CW+1)'(LABEL_WORDS)) begin
							phase_q <= PH_ODD;
							wcnt_q  <= '0;
						end else begin
							wcnt_q <= wcnt_inc[CW-1:0];
						end
					end
					PH_ODD: begin
						if (!lo_half) begin
							hold_q <= w;
						end
						if (wcnt_inc >= (CW+1)'(2 * LONGS)) begin
							phase_q <= PH_EVEN;
							wcnt_q  <= '0;
						end else begin
							wcnt_q <= wcnt_inc[CW-1:0];
						end
					end
					PH_EVEN: begin
						if (!lo_half) begin
							hold_q <= w;
							wcnt_q <= wcnt_inc[CW-1:0];
						end else if (last_long) begin
							if (gap_q && left_q > SECTOR_W'(1)) begin
								phase_q <= PH_HUNT;
							end else if (left_q == SECTOR_W'(1)) begin
								phase_q <= PH_IDLE;
							end else begin
								phase_q <= PH_GAP;
							end
							left_q <= left_q - SECTOR_W'(1);
							wcnt_q <= '0;
						end else begin
							wcnt_q <= wcnt_inc[CW-1:0];
						end
					end
					PH_GAP: begin
						if (wcnt_inc >= (CW+1)'(GAP_WORDS)) begin
							phase_q <= PH_HEADER;
							wcnt_q  <= '0;
						end else begin
							wcnt_q <= wcnt_inc[CW-1:0];
						end
					end
					PH_HUNT: begin
						if (is_sync) begin
							phase_q <= PH_SKIPSYNC;
						end
					end
					PH_SKIPSYNC: begin
						if (!is_sync) begin
							phase_q <= PH_HEADER;
							hold_q  <= w;
							wcnt_q  <= CW'(1);
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

[rtl/mtsd_queue.sv]
module mtsd_queue import mtsd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  q_push_t  push,
	input  logic     pop,
	output q_entry_t head,
	output q_stat_t  stat
);

	// depth is a power of two so the pointers wrap on their own
	localparam int PW = $clog2(QUEUE_DEPTH);

	q_entry_t      entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;
	logic          do_pop;

	assign stat.full  = count_q == (PW+1)'(QUEUE_DEPTH);
	assign stat.empty = count_q == '0;
	assign head       = entry_q[rd_ptr_q];
	assign do_pop     = pop && !stat.empty;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push.valid && !do_pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (!push.valid && do_pop) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

endmodule

[rtl/mtsd_back.sv]
module mtsd_back import mtsd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_entry_t  head,
	input  q_stat_t   q_stat,
	output logic      pop,
	mtsd_out_if.source dec_out
);

	logic                    vld_q;
	logic [SECTOR_W-1:0]     sector_q;
	logic [LONG_INDEX_W-1:0] index_q;
	logic [LONG_W-1:0]       long_q;
	logic                    last_q;

	assign pop = !q_stat.empty && (!vld_q || dec_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (pop) begin
			vld_q <= 1'b1;
		end else if (dec_out.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sector_q <= head.sector_number;
			index_q  <= head.long_index;
			long_q   <= mfm_join(head.odd_long, head.even_long);
			last_q   <= head.track_last;
		end
	end

	assign dec_out.valid         = vld_q;
	assign dec_out.sector_number = sector_q;
	assign dec_out.long_index    = index_q;
	assign dec_out.decoded_long  = long_q;
	assign dec_out.track_last    = last_q;

endmodule

[rtl/mfm_track_sector_decoder_core.sv]
// MFM track sector decoder. Raw track words enter on raw_in, one word per
// cycle at full rate; a word with first_word set restarts the track parse
// (a leading sync word is dropped), and sectors_per_track sectors follow.
// Each even data longword gives one item on dec_out, so a sector yields
// LONGS results, one per two input words, with track_last on the final
// longword of the final sector. The front parser takes a word every cycle
// while the two-entry result queue has room; the back stage owns the output
// register and drains the queue one item per cycle, so raw_in only stalls
// once dec_out has been held off long enough to fill the queue. The odd
// halves of a sector live in a single-port-write RAM of LONGS entries; an
// entry is read on the high word of its even half and the registered data
// meets the low word one accept later, so the store read never adds a
// stall. The RAM is not cleared after reset: every
// entry is written in a sector before it is read back. Configuration
// (sync_word, sectors_per_track) is to be written only while no track is
// in progress.
module mfm_track_sector_decoder_core import mtsd_pkg::*; #(
	parameter int LONGS = LONGS_PER_SECTOR
) (
	input  logic                   clk,
	input  logic                   arst_n,
	mtsd_in_if.sink                raw_in,
	mtsd_out_if.source             dec_out,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int IW = $clog2(LONGS);

	cfg_t cfg_q;

	// front to store
	logic              ram_we;
	logic [IW-1:0]     ram_waddr;
	logic [LONG_W-1:0] ram_wdata;
	logic              ram_re;
	logic [IW-1:0]     ram_raddr;
	logic [LONG_W-1:0] ram_rdata;

	// front to queue to back
	q_push_t  push;
	q_entry_t head;
	q_stat_t  q_stat;
	logic     pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_word         <= SYNC_WORD_RESET;
			cfg_q.sectors_per_track <= SECTORS_PER_TRACK_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYNC_WORD: begin
					cfg_q.sync_word <= cfg_data[RAW_W-1:0];
				end
				REG_SECTORS_PER_TRACK: begin
					cfg_q.sectors_per_track <= cfg_data[SECTOR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// parser: phase tracking, header decode, store writes and reads
	mtsd_front #(
		.LONGS(LONGS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.raw_in   (raw_in),
		.q_stat   (q_stat),
		.push     (push),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	// odd half store
	mtsd_ram #(
		.WIDTH(LONG_W),
		.DEPTH(LONGS)
	) u_odd_store (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.re     (ram_re),
		.raddr  (ram_raddr),
		.rdata_q(ram_rdata)
	);

	// decouples the parser from output back-pressure
	mtsd_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.head  (head),
		.stat  (q_stat)
	);

	// mfm join and output register
	mtsd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.dec_out(dec_out)
	);

	// a result is never pushed into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !q_stat.full)
		else $error("result queue overflow");

	// the store is never written and read in the same cycle
	a_ram_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("odd store written and read together");

	// a waiting item reaches an empty output register on the next cycle
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_stat.empty && !dec_out.valid) |=> dec_out.valid)
		else $error("queued item not moved to output");

	// a result push never shares a cycle with a store read
	a_read_before_push: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !ram_re)
		else $error("store read and result push collide");

endmodule

[tb/mfm_track_sector_decoder_core_tb.sv]
`timescale 1ns / 100ps

// track decoder bench: tracks of mfm words are built into a queue, a clocked
// driver feeds them to raw_in, and a clocked monitor runs every accepted item
// through a local parser and checks each decoded longword on dec_out
module mfm_track_sector_decoder_core_tb;
	import mtsd_pkg::*;

	localparam int SETTLE_CYCLES = 8;     // output queue plus output register, with margin
	localparam int IDLE_PCT      = 22;

	// parse phases of the local track parser
	typedef enum logic [2:0] {
		P_IDLE, P_HEADER, P_LABELS, P_ODD, P_EVEN, P_GAP, P_HUNT, P_SKIP
	} parse_e;

	typedef struct packed {
		logic [RAW_W-1:0] raw;
		logic             first;
	} track_word_t;

	typedef struct packed {
		logic [SECTOR_W-1:0]     sector_number;
		logic [LONG_INDEX_W-1:0] long_index;
		logic [LONG_W-1:0]       decoded_long;
		logic                    track_last;
	} dec_long_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	mtsd_in_if  raw_in();
	mtsd_out_if dec_out();

	mfm_track_sector_decoder_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.raw_in   (raw_in),
		.dec_out  (dec_out),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// stimulus and scoreboard
	track_word_t pending_words[$];
	dec_long_t   exp_longs[$];
	int          word_budget = -1;    // words still allowed into the current track, -1 = no cut
	int          words_queued = 0;
	int          words_sent = 0;
	int          pause_at = -1;       // after this many words the sender waits for all results
	int          words_accepted = 0;
	int          longs_checked = 0;
	int          lasts_checked = 0;
	int          tracks_built = 0;
	int          errors = 0;
	int          idle_pct = IDLE_PCT;
	bit          word_taken = 0;

	// local parser state, mirrors the block after reset
	logic [RAW_W-1:0]    m_sync = SYNC_WORD_RESET;
	logic [SECTOR_W-1:0] m_spt = SECTORS_PER_TRACK_RESET;
	parse_e              m_phase = P_IDLE;
	int                  m_count = 0;
	logic [LONG_W-1:0]   m_odd_store [LONGS_PER_SECTOR];
	logic [RAW_W-1:0]    m_hold = '0;
	logic [LONG_W-1:0]   m_hdr_odd = '0;
	logic [SECTOR_W-1:0] m_sector = '0;
	logic                m_gap1 = 1'b0;
	logic [SECTOR_W-1:0] m_left = '0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// odd half carries data bits shifted down by one, even half the rest
	function automatic logic [LONG_W-1:0] mfm_merge(input logic [LONG_W-1:0] odd_l,
		input logic [LONG_W-1:0] even_l);
		mfm_merge = ((odd_l & MFM_MASK) << 1) | (even_l & MFM_MASK);
	endfunction

	function automatic logic [RAW_W-1:0] non_sync_word();
		logic [RAW_W-1:0] w;
		do w = RAW_W'($urandom); while (w == m_sync);
		return w;
	endfunction

	function automatic void check_field(input string what, input logic [LONG_W-1:0] want,
		input logic [LONG_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
			errors++;
		end
	endfunction

	// one accepted track word through the parser; an even data longword
	// yields one expected decoded longword
	task automatic predict_word(input logic [RAW_W-1:0] w, input logic first);
		logic [LONG_W-1:0] lw;
		int                idx;
		if (first) begin
			// a first word restarts the parse, a leading sync is dropped
			m_left = m_spt;
			m_phase = P_HEADER;
			if (w == m_sync) begin
				m_count = 0;
			end else begin
				m_hold = w;
				m_count = 1;
			end
			return;
		end
		lw = {m_hold, w};
		case (m_phase)
			P_HEADER: begin
				if (m_count[0] == 1'b0) begin
					m_hold = w;
					m_count++;
				end else if (m_count == 1) begin
					m_hdr_odd = lw;
					m_count++;
				end else begin
					// header info: sector number in 15..8, gap distance in 7..0
					lw = mfm_merge(m_hdr_odd, lw);
					m_sector = lw[15:8];
					m_gap1 = (lw[7:0] == 8'd1);
					m_phase = P_LABELS;
					m_count = 0;
				end
			end
			P_LABELS: begin
				// labels and checksums are skipped, never verified
				m_count++;
				if (m_count >= LABEL_WORDS) begin
					m_phase = P_ODD;
					m_count = 0;
				end
			end
			P_ODD: begin
				if (m_count[0] == 1'b0)
					m_hold = w;
				else
					m_odd_store[(m_count >> 1) % LONGS_PER_SECTOR] = lw;
				m_count++;
				if (m_count >= 2 * LONGS_PER_SECTOR) begin
					m_phase = P_EVEN;
					m_count = 0;
				end
			end
			P_EVEN: begin
				if (m_count[0] == 1'b0) begin
					m_hold = w;
					m_count++;
				end else begin
					idx = (m_count >> 1) % LONGS_PER_SECTOR;
					exp_longs.push_back('{m_sector, LONG_INDEX_W'(idx),
						mfm_merge(m_odd_store[idx], lw),
						(idx == LONGS_PER_SECTOR - 1) && (m_left == 8'd1)});
					m_count++;
					if (idx == LONGS_PER_SECTOR - 1) begin
						// gap distance of one means a sync run before the next header
						if (m_gap1 && m_left > 8'd1)
							m_phase = P_HUNT;
						else if (m_left == 8'd1)
							m_phase = P_IDLE;
						else
							m_phase = P_GAP;
						m_left--;
						m_count = 0;
					end
				end
			end
			P_GAP: begin
				m_count++;
				if (m_count >= GAP_WORDS) begin
					m_phase = P_HEADER;
					m_count = 0;
				end
			end
			P_HUNT: if (w == m_sync) m_phase = P_SKIP;
			P_SKIP: begin
				// first word past the sync run opens the next header
				if (w != m_sync) begin
					m_phase = P_HEADER;
					m_hold = w;
					m_count = 1;
				end
			end
			default: ;
		endcase
	endtask

	task automatic push_word(input logic [RAW_W-1:0] w, input logic first);
		if (word_budget != 0) begin
			pending_words.push_back('{w, first});
			words_queued++;
			if (word_budget > 0) word_budget--;
		end
	endtask

	// one track at the current settings; hunt_mode 0 picks gap distances at
	// random, 1 forces a sync run between sectors, 2 forces a hunt whose sync
	// never comes (the track stops there and the parser keeps hunting)
	task automatic push_track(input bit lead_sync, input bit extremes, input int hunt_mode);
		logic [SECTOR_W-1:0] left;
		logic [SECTOR_W-1:0] sec;
		logic [7:0]          gap;
		logic [LONG_W-1:0]   info;
		logic [LONG_W-1:0]   odd_h;
		logic [LONG_W-1:0]   even_h;
		logic                first;
		int                  j;
		left = m_spt;    // zero wraps, so 256 sectors
		first = 1'b1;
		tracks_built++;
		if (lead_sync) begin
			push_word(m_sync, 1'b1);
			first = 1'b0;
		end
		forever begin
			sec = extremes ? {SECTOR_W{tracks_built[0]}} : SECTOR_W'($urandom);
			gap = (hunt_mode != 0 || $urandom_range(1) == 1) ? 8'd1 : 8'($urandom);
			info = {8'hff, 8'($urandom_range(159)), sec, gap};
			// clock bit positions get random values, the decoder masks them off
			odd_h = ((info >> 1) & MFM_MASK) | ($urandom & ~MFM_MASK);
			even_h = (info & MFM_MASK) | ($urandom & ~MFM_MASK);
			// header must not open with a sync word; bit 31 is a clock bit
			if (odd_h[31:16] == m_sync) odd_h[31] = ~odd_h[31];
			push_word(odd_h[31:16], first);
			first = 1'b0;
			push_word(odd_h[15:0], 1'b0);
			push_word(even_h[31:16], 1'b0);
			push_word(even_h[15:0], 1'b0);
			repeat (LABEL_WORDS) push_word(RAW_W'($urandom), 1'b0);
			// odd then even data; extremes alternate all-zero and all-one longwords
			for (j = 0; j < 4 * LONGS_PER_SECTOR; j++)
				push_word(extremes ? {RAW_W{j[1]}} : RAW_W'($urandom), 1'b0);
			if (left == 8'd1) break;
			if (gap == 8'd1 && left > 8'd1) begin
				repeat ($urandom_range(4)) push_word(non_sync_word(), 1'b0);
				if (hunt_mode == 2) begin
					repeat (6) push_word(non_sync_word(), 1'b0);
					return;
				end
				repeat ($urandom_range(1, 3)) push_word(m_sync, 1'b0);
			end else begin
				repeat (GAP_WORDS) push_word(RAW_W'($urandom), 1'b0);
			end
			left--;
		end
	endtask

	// registers only change with the block idle, so the local copy follows at once
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SYNC_WORD)
			m_sync = val;
		else
			m_spt = val[SECTOR_W-1:0];
	endtask

	// sender holds off until every expected longword is back, then lets the
	// block settle
	task automatic wait_drained();
		while (pending_words.size() != 0 || raw_in.valid || exp_longs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// driver: new item or idle at the falling edge, random output stalls;
	// at the pause point nothing is sent until every expected result is back
	always @(negedge clk) begin
		track_word_t next_w;
		if (arst_n) begin
			if (!raw_in.valid || word_taken) begin
				if (pending_words.size() != 0
					&& !(words_sent == pause_at && exp_longs.size() != 0)
					&& $urandom_range(99) >= idle_pct) begin
					next_w = pending_words.pop_front();
					words_sent++;
					raw_in.valid <= 1'b1;
					raw_in.raw_word <= next_w.raw;
					raw_in.first_word <= next_w.first;
				end else begin
					raw_in.valid <= 1'b0;
				end
			end
			word_taken = 1'b0;
			dec_out.ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// monitor: accepted items feed the parser, results are checked in order
	always @(posedge clk) begin
		dec_long_t want;
		if (arst_n) begin
			if (raw_in.valid && raw_in.ready) begin
				predict_word(raw_in.raw_word, raw_in.first_word);
				word_taken = 1'b1;
				words_accepted++;
			end
			if (dec_out.valid && dec_out.ready) begin
				if (exp_longs.size() == 0) begin
					$display("%0t: unexpected item, expected none, got sector %0h index %0d %0h",
						$time, dec_out.sector_number, dec_out.long_index, dec_out.decoded_long);
					errors++;
				end else begin
					want = exp_longs.pop_front();
					check_field("sector_number", LONG_W'(want.sector_number),
						LONG_W'(dec_out.sector_number));
					check_field("long_index", LONG_W'(want.long_index),
						LONG_W'(dec_out.long_index));
					check_field("decoded_long", want.decoded_long, dec_out.decoded_long);
					check_field("track_last", LONG_W'(want.track_last),
						LONG_W'(dec_out.track_last));
					longs_checked++;
					if (want.track_last) lasts_checked++;
				end
			end
		end
	end

	initial begin
		int main_start;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SYNC_WORD;
		cfg_data = '0;
		raw_in.valid = 1'b0;
		raw_in.raw_word = '0;
		raw_in.first_word = 1'b0;
		dec_out.ready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// a fresh sync marker and two sectors per track for the whole run
		write_reg(REG_SYNC_WORD, CFG_DATA_W'($urandom));
		write_reg(REG_SECTORS_PER_TRACK, 16'd2);

		// noise before any first word is ignored
		push_word(16'h0000, 1'b0);
		push_word(16'hffff, 1'b0);
		push_word(m_sync, 1'b0);
		// a track cut inside its labels; the next first word drops it
		word_budget = 12;
		push_track(1'b0, 1'b0, 1);
		word_budget = -1;
		// full track opened by a sync, with a sync run between the sectors;
		// halfway through the first even half the sender waits for all results
		main_start = words_queued;
		pause_at = main_start + 1 + 4 + LABEL_WORDS + 3 * LONGS_PER_SECTOR;
		push_track(1'b1, 1'b0, 1);
		// words after the last sector are ignored
		push_word(16'hffff, 1'b0);
		push_word(m_sync, 1'b0);

		// no idling on either side for a stretch inside the second sector's data
		wait (words_accepted >= main_start + 600);
		idle_pct = 0;
		wait (words_accepted >= main_start + 1000);
		idle_pct = IDLE_PCT;
		wait_drained();

		errors += exp_longs.size();
		$display("covered %0d tracks, %0d words accepted, %0d decoded longwords checked",
			tracks_built, words_accepted, longs_checked);
		$display("track ends seen %0d; noise, a cut track, a sync run and a drain pause",
			lasts_checked);
		if (errors == 0) begin
			$display("mfm_track_sector_decoder_core_tb: done, clean");
		end else begin
			$display("mfm_track_sector_decoder_core_tb: done, errors");
		end
		$finish;
	end

	// about 1100 words are sent in all; the timeout is far longer than they take
	initial begin
		#400_000;
		$display("%0t: timeout, %0d longwords still expected", $time, exp_longs.size());
		$display("mfm_track_sector_decoder_core_tb: done, errors");
		$finish;
	end

endmodule

[sim.f]
rtl/mtsd_pkg.sv
rtl/mtsd_if.sv
rtl/mtsd_ram.sv
rtl/mtsd_front.sv
rtl/mtsd_queue.sv
rtl/mtsd_back.sv
rtl/mfm_track_sector_decoder_core.sv
tb/mfm_track_sector_decoder_core_tb.sv
